### design/mlpc_pkg.sv
package mlpc_pkg;

   localparam int LIGHT_FULL_SCALE = 4095;

   localparam int TIME_W     = 32;
   localparam int LIGHT_W    = 12;
   localparam int PCT_W      = 7;
   localparam int PRESET_W   = 8;
   localparam int DELAY_S_W  = 15;
   localparam int DELAY_MS_W = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam logic [TIME_W-1:0]     SAMPLE_GAP_MS    = 32'd250;
   localparam logic [TIME_W-1:0]     REPORT_CHANGE_MS = 32'd10000;
   localparam logic [TIME_W-1:0]     REFRESH_MS       = 32'd600000;
   localparam logic [LIGHT_W-1:0]    LIGHT_STEP       = 12'd32;
   localparam logic [PCT_W-1:0]      PCT_MAX          = 7'd100;
   localparam logic [DELAY_MS_W-1:0] MS_PER_S         = 25'd1000;

   // Rounded percent by reciprocal multiplication:
   // pct = floor((light * 200 + FS) / (2 * FS)) = (light * C1 + C0) >> PCT_SHIFT.
   localparam longint PCT_DEN    = 2 * LIGHT_FULL_SCALE;
   localparam int     PCT_NUM_W  = 20;
   localparam int     PCT_SHIFT  = PCT_NUM_W + $clog2(PCT_DEN);
   localparam longint PCT_MULT   = ((longint'(1) << PCT_SHIFT) + PCT_DEN - 1) / PCT_DEN;
   localparam longint PCT_C1     = 200 * PCT_MULT;
   localparam longint PCT_C0     = LIGHT_FULL_SCALE * PCT_MULT;
   localparam int     PCT_Q_W    = 11;
   localparam int     PCT_PROD_W = PCT_SHIFT + PCT_Q_W;

   localparam logic                  RST_ENABLE       = 1'b0;
   localparam logic [PCT_W-1:0]      RST_ON_THR_PCT   = 7'd40;
   localparam logic [PCT_W-1:0]      RST_OFF_THR_PCT  = 7'd50;
   localparam logic [PRESET_W-1:0]   RST_ON_PRESET    = 8'd1;
   localparam logic [PRESET_W-1:0]   RST_OFF_PRESET   = 8'd10;
   localparam logic [DELAY_MS_W-1:0] RST_OFF_DELAY_MS = 25'd60000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_ON_THRESHOLD  = 3'd1,
      CSR_OFF_THRESHOLD = 3'd2,
      CSR_ON_PRESET     = 3'd3,
      CSR_OFF_PRESET    = 3'd4,
      CSR_OFF_DELAY     = 3'd5
   } mlpc_csr_index_type;

   typedef enum logic [1:0] {
      MOTION_NONE = 2'd0,
      MOTION_ON   = 2'd1,
      MOTION_OFF  = 2'd2
   } mlpc_motion_event_type;

   typedef struct packed {
      logic                  enable;
      logic [PCT_W-1:0]      on_threshold_pct;
      logic [PCT_W-1:0]      off_threshold_pct;
      logic [PRESET_W-1:0]   on_preset;
      logic [PRESET_W-1:0]   off_preset;
      logic [DELAY_MS_W-1:0] off_delay_ms;
   } mlpc_cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [LIGHT_W-1:0] light_level;
      logic               motion;
      logic               lights_off;
      logic [PCT_W-1:0]   light_pct;
   } mlpc_item_type;

   typedef struct packed {
      logic                  preset_valid;
      logic [PRESET_W-1:0]   preset_number;
      mlpc_motion_event_type motion_event;
      logic                  motion_refresh;
      logic                  light_report_valid;
      logic [PCT_W-1:0]      light_pct;
   } mlpc_result_type;

endpackage

### design/motion_light_preset_controller.sv
// Motion and light preset controller.
// Each request on the req_ channel is one poll: a millisecond timestamp, an
// ambient light sample, the motion level and whether the lights are off. While
// enabled, every request gives exactly one response on the rsp_ channel with the
// preset request, motion reports, the light report flag and the brightness percent.
// While disabled, requests are consumed and give no response.
// Registers are written on the csr_ channel, which is always ready; the user must
// see that they are written only while no request is in flight, as the block
// itself does not enforce this. An accepted request is held in the input register
// and moves to the response register once that is free. The input register also
// holds the scaled brightness percent, and the decision logic and state update feed
// the response register. One request is accepted per cycle while rsp_tready is high.
// Reset restores register defaults (disabled) and clears valid flags and step state.
// When the receiver stalls, the response register holds its request, the input
// register fills, and req_tready drops until rsp_tready returns high.
module motion_light_preset_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms[31:0], light_level[43:32], motion[44], lights_off[45], zero[47:46]
   input  logic [mlpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // preset_valid[0], preset_number[8:1], motion_event[10:9], motion_refresh[11],
   // light_report_valid[12], light_pct[19:13], zero[23:20]
   output logic [mlpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mlpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mlpc_pkg::CSR_DATA_W-1:0]     csr_data
);

   mlpc_pkg::mlpc_cfg_type    cfg_ff, cfg_in;
   mlpc_pkg::mlpc_item_type   item_ff, item_in;
   logic                      item_valid_ff, item_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [mlpc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   mlpc_pkg::mlpc_result_type result;

   logic [mlpc_pkg::PCT_PROD_W-1:0] pct_prod;
   logic [mlpc_pkg::PCT_Q_W-1:0]    pct_quot;
   logic                            out_free;
   logic                            item_move;
   logic                            step_fire;
   logic                            req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (mlpc_pkg::mlpc_csr_index_type'(csr_index))
            mlpc_pkg::CSR_ENABLE:        cfg_in.enable            = csr_data[0];
            mlpc_pkg::CSR_ON_THRESHOLD:  cfg_in.on_threshold_pct  = csr_data[6:0];
            mlpc_pkg::CSR_OFF_THRESHOLD: cfg_in.off_threshold_pct = csr_data[6:0];
            mlpc_pkg::CSR_ON_PRESET:     cfg_in.on_preset         = csr_data[7:0];
            mlpc_pkg::CSR_OFF_PRESET:    cfg_in.off_preset        = csr_data[7:0];
            mlpc_pkg::CSR_OFF_DELAY:     cfg_in.off_delay_ms      =
               mlpc_pkg::DELAY_MS_W'(csr_data[mlpc_pkg::DELAY_S_W-1:0]) * mlpc_pkg::MS_PER_S;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   assign pct_prod = mlpc_pkg::PCT_PROD_W'(req_tdata[43:32]) *
                     mlpc_pkg::PCT_PROD_W'(mlpc_pkg::PCT_C1) +
                     mlpc_pkg::PCT_PROD_W'(mlpc_pkg::PCT_C0);
   assign pct_quot = pct_prod[mlpc_pkg::PCT_PROD_W-1:mlpc_pkg::PCT_SHIFT];

   always_comb begin
      item_in.now_ms      = req_tdata[31:0];
      item_in.light_level = req_tdata[43:32];
      item_in.motion      = req_tdata[44];
      item_in.lights_off  = req_tdata[45];
      item_in.light_pct   = (pct_quot > mlpc_pkg::PCT_Q_W'(mlpc_pkg::PCT_MAX))
                            ? mlpc_pkg::PCT_MAX : pct_quot[mlpc_pkg::PCT_W-1:0];
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign item_move  = item_valid_ff && out_free;
   assign step_fire  = item_move && cfg_ff.enable;
   assign req_tready = !item_valid_ff || item_move;
   assign req_take   = req_tvalid && req_tready;

   assign item_valid_in = req_take ? 1'b1 : (item_move ? 1'b0 : item_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (item_move) begin
         rsp_valid_in = cfg_ff.enable;
         rsp_data_in  = {4'b0000, result.light_pct, result.light_report_valid,
                         result.motion_refresh, 2'(result.motion_event),
                         result.preset_number, result.preset_valid};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   mlpc_step u_step (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .item   (item_ff),
      .fire   (step_fire),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable            <= mlpc_pkg::RST_ENABLE;
         cfg_ff.on_threshold_pct  <= mlpc_pkg::RST_ON_THR_PCT;
         cfg_ff.off_threshold_pct <= mlpc_pkg::RST_OFF_THR_PCT;
         cfg_ff.on_preset         <= mlpc_pkg::RST_ON_PRESET;
         cfg_ff.off_preset        <= mlpc_pkg::RST_OFF_PRESET;
         cfg_ff.off_delay_ms      <= mlpc_pkg::RST_OFF_DELAY_MS;
         item_valid_ff            <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/mlpc_step.sv
module mlpc_step (
   input  logic                     clock,
   input  logic                     reset,
   input  mlpc_pkg::mlpc_cfg_type   cfg,
   input  mlpc_pkg::mlpc_item_type  item,
   input  logic                     fire,
   output mlpc_pkg::mlpc_result_type result
);

   logic [mlpc_pkg::TIME_W-1:0]  last_sample_time_ff, last_sample_time_in;
   logic                         prev_motion_ff, prev_motion_in;
   logic [mlpc_pkg::LIGHT_W-1:0] prev_light_ff, prev_light_in;
   logic [mlpc_pkg::PCT_W-1:0]   bright_pct_ff, bright_pct_in;
   logic [mlpc_pkg::PCT_W-1:0]   reported_pct_ff, reported_pct_in;
   logic                         motion_armed_ff, motion_armed_in;
   logic                         on_active_ff, on_active_in;
   logic [mlpc_pkg::TIME_W-1:0]  last_motion_time_ff, last_motion_time_in;
   logic [mlpc_pkg::TIME_W-1:0]  last_report_time_ff, last_report_time_in;

   logic [mlpc_pkg::TIME_W-1:0]  sample_dt;
   logic [mlpc_pkg::TIME_W-1:0]  idle_dt;
   logic [mlpc_pkg::TIME_W-1:0]  report_dt;
   logic [mlpc_pkg::TIME_W-1:0]  refresh_dt;
   logic [mlpc_pkg::LIGHT_W-1:0] light_diff;
   logic                         motion_changed;

   assign sample_dt  = item.now_ms - last_sample_time_ff;
   assign idle_dt    = item.now_ms - last_motion_time_ff;
   assign report_dt  = item.now_ms - last_report_time_ff;
   assign light_diff = (item.light_level > prev_light_ff) ? item.light_level - prev_light_ff
                                                          : prev_light_ff - item.light_level;
   assign motion_changed = item.motion != prev_motion_ff;

   always_comb begin
      last_sample_time_in = last_sample_time_ff;
      prev_motion_in      = prev_motion_ff;
      prev_light_in       = prev_light_ff;
      bright_pct_in       = bright_pct_ff;
      reported_pct_in     = reported_pct_ff;
      motion_armed_in     = motion_armed_ff;
      on_active_in        = on_active_ff;
      last_motion_time_in = last_motion_time_ff;
      last_report_time_in = last_report_time_ff;
      result              = '0;
      result.motion_event = mlpc_pkg::MOTION_NONE;

      if (sample_dt > mlpc_pkg::SAMPLE_GAP_MS) begin
         if (motion_changed || light_diff > mlpc_pkg::LIGHT_STEP) begin
            bright_pct_in = item.light_pct;
            if (motion_changed) begin
               result.motion_event = item.motion ? mlpc_pkg::MOTION_ON : mlpc_pkg::MOTION_OFF;
            end
            if (item.motion) begin
               if (item.lights_off && item.light_pct < cfg.on_threshold_pct) begin
                  result.preset_valid  = 1'b1;
                  result.preset_number = cfg.on_preset;
                  motion_armed_in      = 1'b1;
                  on_active_in         = 1'b1;
               end else if (motion_armed_ff && !on_active_ff &&
                            item.light_pct < cfg.off_threshold_pct) begin
                  result.preset_valid  = 1'b1;
                  result.preset_number = cfg.on_preset;
                  on_active_in         = 1'b1;
               end
            end else if (motion_armed_ff && on_active_ff) begin
               if (item.light_pct > cfg.off_threshold_pct) begin
                  result.preset_valid  = 1'b1;
                  result.preset_number = cfg.off_preset;
                  on_active_in         = 1'b0;
               end else if (prev_motion_ff) begin
                  last_motion_time_in = item.now_ms;
               end
            end
            prev_motion_in = item.motion;
            prev_light_in  = item.light_level;
         end else if (motion_armed_ff) begin
            if (item.lights_off) begin
               motion_armed_in = 1'b0;
            end else if (on_active_ff && !item.motion &&
                         idle_dt > mlpc_pkg::TIME_W'(cfg.off_delay_ms)) begin
               result.preset_valid  = 1'b1;
               result.preset_number = cfg.off_preset;
               on_active_in         = 1'b0;
            end
         end
         last_sample_time_in = item.now_ms;
      end

      if ((report_dt > mlpc_pkg::REPORT_CHANGE_MS && bright_pct_in != reported_pct_ff) ||
          report_dt > mlpc_pkg::REFRESH_MS) begin
         result.light_report_valid = 1'b1;
         reported_pct_in           = bright_pct_in;
         last_report_time_in       = item.now_ms;
      end

      refresh_dt = item.now_ms - last_motion_time_in;
      if (refresh_dt > mlpc_pkg::REFRESH_MS) begin
         result.motion_refresh = 1'b1;
         last_motion_time_in   = item.now_ms;
      end

      result.light_pct = bright_pct_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_time_ff <= '0;
         prev_motion_ff      <= 1'b0;
         prev_light_ff       <= '0;
         bright_pct_ff       <= '0;
         reported_pct_ff     <= '0;
         motion_armed_ff     <= 1'b0;
         on_active_ff        <= 1'b0;
         last_motion_time_ff <= '0;
         last_report_time_ff <= '0;
      end else if (fire) begin
         last_sample_time_ff <= last_sample_time_in;
         prev_motion_ff      <= prev_motion_in;
         prev_light_ff       <= prev_light_in;
         bright_pct_ff       <= bright_pct_in;
         reported_pct_ff     <= reported_pct_in;
         motion_armed_ff     <= motion_armed_in;
         on_active_ff        <= on_active_in;
         last_motion_time_ff <= last_motion_time_in;
         last_report_time_ff <= last_report_time_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      result.preset_valid |->
         (result.preset_number == cfg.on_preset || result.preset_number == cfg.off_preset))
      else $error("Preset request names neither configured preset.");

   assert property (@(posedge clock) disable iff (reset)
      !result.preset_valid |-> result.preset_number == '0)
      else $error("Preset number given without a preset request.");

   assert property (@(posedge clock) disable iff (reset)
      fire && result.light_report_valid |=> reported_pct_ff == bright_pct_ff)
      else $error("Reported percent does not follow a light report.");

   assert property (@(posedge clock) disable iff (reset)
      bright_pct_ff <= mlpc_pkg::PCT_MAX)
      else $error("Brightness percent above full scale.");

   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(last_sample_time_ff) && $stable(on_active_ff))
      else $error("State changed without an accepted request.");

endmodule
